### rtl/pulse_qualified_serial_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-qualified serial receiver
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_QUALIFIED_SERIAL_RECEIVER_CORE_MACROS_SVH
`define PULSE_QUALIFIED_SERIAL_RECEIVER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqsr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqsr assertion failed");

`endif

### rtl/pqsr_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-qualified serial receiver package
// Shared constants, register codes, phase encoding and interface structs.
// ----------------------------------------------------------------------------
package pqsr_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(DATA_BITS - 1);

  localparam logic [BYTE_W-1:0] HASH_CODE    = 8'h23;
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

  localparam logic             RST_ENABLE       = 1'b1;
  localparam logic [CNT_W-1:0] RST_QUALIFY      = 16'd200;
  localparam logic [CNT_W-1:0] RST_FIRST_SAMPLE = 16'd105;
  localparam logic [CNT_W-1:0] RST_BIT_PERIOD   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECEIVE_ENABLE = 2'd0,
    CFG_QUALIFY_TICKS  = 2'd1,
    CFG_FIRST_SAMPLE   = 2'd2,
    CFG_BIT_PERIOD     = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_QUALIFY = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_FIRST   = 5'b01000,
    PH_BITS    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic             enable;
    logic [CNT_W-1:0] qualify;
    logic [CNT_W-1:0] first_sample;
    logic [CNT_W-1:0] bit_period;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] data;
  } rx_result_t;

  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

  function automatic logic [BYTE_W-1:0] map_byte(input logic [DATA_BITS-1:0] s);
    logic [BYTE_W+DATA_BITS-1:0] ext;
    logic [BYTE_W-1:0]           b;
    ext = {{BYTE_W{1'b0}}, s};
    b   = ext[BYTE_W-1:0];
    return (b == HASH_CODE) ? NEWLINE_CODE : b;
  endfunction

endpackage

### rtl/pqsr_rx_fsm.sv
// ----------------------------------------------------------------------------
// Receiver phase sequencer
// Arms on a rising edge, qualifies the pulse, waits for the falling edge and
// samples the data bits; one line sample is taken per step.
// ----------------------------------------------------------------------------
module pqsr_rx_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 line_level,
  input  pqsr_pkg::cfg_t       cfg,
  output pqsr_pkg::rx_result_t result
);
  import pqsr_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic                   prev_level_r, prev_level_nxt;
  logic [CNT_W-1:0]       tick_cnt_r, tick_cnt_nxt;
  logic [BIT_IDX_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [DATA_BITS-1:0]   shift_r, shift_nxt;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   take;
  logic                   done;

  assign cnt_inc = tick_cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    prev_level_nxt = line_level;
    tick_cnt_nxt   = tick_cnt_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    take           = 1'b0;
    done           = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (cfg.enable && line_level && !prev_level_r) begin
          phase_nxt    = PH_QUALIFY;
          tick_cnt_nxt = '0;
        end
      end
      PH_QUALIFY: begin
        if (!line_level) begin
          phase_nxt    = PH_IDLE;
          tick_cnt_nxt = '0;
        end else if (cnt_inc >= at_least_one(cfg.qualify)) begin
          phase_nxt    = PH_WAIT;
          tick_cnt_nxt = '0;
        end else begin
          tick_cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (!line_level) begin
          phase_nxt    = PH_FIRST;
          tick_cnt_nxt = '0;
          bit_idx_nxt  = '0;
          shift_nxt    = '0;
        end
      end
      PH_FIRST: begin
        if (cnt_inc >= at_least_one(cfg.first_sample)) begin
          tick_cnt_nxt = '0;
          take         = 1'b1;
          phase_nxt    = PH_BITS;
        end else begin
          tick_cnt_nxt = cnt_inc;
        end
      end
      PH_BITS: begin
        if (cnt_inc >= at_least_one(cfg.bit_period)) begin
          tick_cnt_nxt = '0;
          take         = 1'b1;
        end else begin
          tick_cnt_nxt = cnt_inc;
        end
      end
      default: begin
        phase_nxt    = PH_IDLE;
        tick_cnt_nxt = '0;
      end
    endcase

    if (take) begin
      shift_nxt[bit_idx_r] = line_level;
      bit_idx_nxt          = bit_idx_r + BIT_IDX_W'(1);
      done                 = (bit_idx_r == LAST_BIT_IDX);
    end

    if (done) begin
      phase_nxt    = PH_IDLE;
      tick_cnt_nxt = '0;
      bit_idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_level_r <= 1'b1;
      tick_cnt_r   <= '0;
      bit_idx_r    <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      prev_level_r <= prev_level_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_r <= shift_nxt;
    end
  end

  assign result.done = step && done;
  assign result.data = map_byte(shift_nxt);

endmodule

### rtl/pulse_qualified_serial_receiver_core.sv
// A byte appears on the output in the cycle after the request holding its last sample.
// Throughput: one line sample per cycle while the input is not stalled; the output register decouples the two sides.
// The input stalls only while a finished byte is held and the output side stalls.
// Reset (synchronous, rst_n low) restores default registers and returns to idle.
// ----------------------------------------------------------------------------
// Pulse-qualified serial receiver core
// Decodes an LSB-first serial byte from per-tick line samples after a
// qualified high pulse, with configuration registers and an output register.
// ----------------------------------------------------------------------------
`include "pulse_qualified_serial_receiver_core_macros.svh"

module pulse_qualified_serial_receiver_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_line_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pqsr_pkg::BYTE_W-1:0]          out_received_byte,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pqsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pqsr_pkg::CNT_W-1:0]           cfg_data
);
  import pqsr_pkg::*;

  cfg_t              cfg_r;
  rx_result_t        result;
  logic              in_accept;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= RST_ENABLE;
      cfg_r.qualify      <= RST_QUALIFY;
      cfg_r.first_sample <= RST_FIRST_SAMPLE;
      cfg_r.bit_period   <= RST_BIT_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RECEIVE_ENABLE: cfg_r.enable       <= cfg_data[0];
        CFG_QUALIFY_TICKS:  cfg_r.qualify      <= cfg_data;
        CFG_FIRST_SAMPLE:   cfg_r.first_sample <= cfg_data;
        CFG_BIT_PERIOD:     cfg_r.bit_period   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pqsr_rx_fsm u_rx_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_accept),
    .line_level (in_line_level),
    .cfg        (cfg_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.done) begin
      out_byte_r <= result.data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_received_byte = out_byte_r;

  `PQSR_ASSERT_SAME(a_done_needs_accept, clk, rst_n, result.done, in_accept)
  `PQSR_ASSERT_SAME(a_stall_needs_held, clk, rst_n, in_stall, out_valid_r && out_stall)
  `PQSR_ASSERT_SAME(a_no_hash_out, clk, rst_n, out_valid, out_received_byte != HASH_CODE)
  `PQSR_ASSERT_NEXT(a_done_loads_out, clk, rst_n, result.done, out_valid)

endmodule
